/* rtl/core/shortest_float_encoder_core_macros.svh */
// Assertion helpers for the float encoder core
`ifndef SHORTEST_FLOAT_ENCODER_CORE_MACROS_SVH
`define SHORTEST_FLOAT_ENCODER_CORE_MACROS_SVH
`define SFE_ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SFE_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

/* rtl/core/sfe_pkg.sv */
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared constants and types for the shortest float encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sfe_pkg;
	localparam logic [7:0] HEAD_HALF   = 8'hf9;
	localparam logic [7:0] HEAD_SINGLE = 8'hfa;
	localparam logic [7:0] HEAD_DOUBLE = 8'hfb;
	localparam logic [3:0] BYTES_HALF   = 4'd2;
	localparam logic [3:0] BYTES_SINGLE = 4'd4;
	localparam logic [3:0] BYTES_DOUBLE = 4'd8;
	localparam logic [10:0] DBL_BIAS = 11'd1023;

	// classification produced by stage 1
	typedef struct packed {
		logic        special;   // nan, inf or zero, payload fixed
		logic [15:0] spec_half;
		logic        dsub;      // double subnormal
		logic        sign;
		logic [10:0] expf;
		logic [51:0] frac;
	} sfe_cls_t;

	// candidate forms produced by stage 2
	typedef struct packed {
		logic        half_ok;
		logic [15:0] half_bits;
		logic        single_ok;
		logic [31:0] single_bits;
	} sfe_cand_t;
endpackage

/* rtl/core/sfe_cand.sv */
// ----------------------------------------------------------------------------
// sfe_cand
// Tests one normal double for exact half and single representations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sfe_cand import sfe_pkg::*; (
	input  sfe_cls_t  cls,
	output sfe_cand_t cand
);
	logic [52:0] sig;
	logic [10:0] expf;
	logic [5:0]  sh_h, sh_s;
	logic [52:0] mask_h, mask_s, q_h, q_s;

	assign sig  = {1'b1, cls.frac};
	assign expf = cls.expf;

	always_comb begin
		cand = '0;
		sh_h = '0;
		sh_s = '0;
		mask_h = '0;
		mask_s = '0;
		q_h = '0;
		q_s = '0;
		// half: biased exp 1009..1038 normal; 1051-e=sh, sh<=52 -> expf>=999
		if (expf >= 11'd1009 && expf <= 11'd1038) begin
			cand.half_ok   = (cls.frac[41:0] == '0);
			cand.half_bits = {cls.sign, 5'(expf - 11'd1008), cls.frac[51:42]};
		end else if (expf < 11'd1009 && expf >= 11'd999) begin
			sh_h   = 6'(11'd1051 - expf);
			mask_h = (53'd1 << sh_h) - 53'd1;
			q_h    = sig >> sh_h;
			cand.half_ok   = ((sig & mask_h) == '0) && (q_h != '0) && (q_h <= 53'd1023);
			cand.half_bits = {cls.sign, 5'd0, q_h[9:0]};
		end
		if (expf >= 11'd897 && expf <= 11'd1150) begin
			cand.single_ok   = (cls.frac[28:0] == '0);
			cand.single_bits = {cls.sign, 8'(expf - 11'd896), cls.frac[51:29]};
		end else if (expf < 11'd897 && expf >= 11'd874) begin
			sh_s   = 6'(11'd926 - expf);
			mask_s = (53'd1 << sh_s) - 53'd1;
			q_s    = sig >> sh_s;
			cand.single_ok   = ((sig & mask_s) == '0) && (q_s != '0) && (q_s < 53'h800000);
			cand.single_bits = {cls.sign, 8'd0, q_s[22:0]};
		end
	end
endmodule

/* rtl/core/shortest_float_encoder_core.sv */
// Throughput: one value per cycle unless the output stalls; each of the three stages is a
// register set with its own valid bit, all advancing when the output side moves.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// shortest_float_encoder_core
// Canonical CBOR float encoder: shortest exact half, single or double form.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "shortest_float_encoder_core_macros.svh"
module shortest_float_encoder_core import sfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [63:0] value_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  head_byte,
	output logic [63:0] payload,
	output logic [3:0]  payload_bytes
);
	logic        v_s1, v_s2, v_s3;
	logic        adv;
	sfe_cls_t    cls_s1, cls_s2, cls_c;
	logic [63:0] bits_s1, bits_s2;
	sfe_cand_t   cand_c, cand_s2;

	// pipeline moves as a whole; empty slot at the end lets it fill
	assign adv   = out_ready || !v_s3;
	assign ready = adv;

	always_comb begin
		cls_c = '0;
		cls_c.sign = value_bits[63];
		cls_c.expf = value_bits[62:52];
		cls_c.frac = value_bits[51:0];
		if (value_bits[62:52] == 11'h7ff) begin
			cls_c.special = 1'b1;
			if (value_bits[51:0] != '0) cls_c.spec_half = 16'h7e00;
			else cls_c.spec_half = value_bits[63] ? 16'hfc00 : 16'h7c00;
		end else if (value_bits[62:52] == '0) begin
			if (value_bits[51:0] == '0) begin
				cls_c.special   = 1'b1;
				cls_c.spec_half = {value_bits[63], 15'd0};
			end else begin
				cls_c.dsub = 1'b1;
			end
		end
	end

	sfe_cand u_cand (.cls(cls_s1), .cand(cand_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s1  <= cls_c;
			bits_s1 <= value_bits;
			cls_s2  <= cls_s1;
			bits_s2 <= bits_s1;
			cand_s2 <= cand_c;
			if (cls_s2.special) begin
				head_byte     <= HEAD_HALF;
				payload       <= {48'd0, cls_s2.spec_half};
				payload_bytes <= BYTES_HALF;
			end else if (!cls_s2.dsub && cand_s2.half_ok) begin
				head_byte     <= HEAD_HALF;
				payload       <= {48'd0, cand_s2.half_bits};
				payload_bytes <= BYTES_HALF;
			end else if (!cls_s2.dsub && cand_s2.single_ok) begin
				head_byte     <= HEAD_SINGLE;
				payload       <= {32'd0, cand_s2.single_bits};
				payload_bytes <= BYTES_SINGLE;
			end else begin
				head_byte     <= HEAD_DOUBLE;
				payload       <= bits_s2;
				payload_bytes <= BYTES_DOUBLE;
			end
		end
	end

	assign out_valid = v_s3;

	`SFE_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(payload), "stalled result changed")
	`SFE_ASSERT_IMPL(a_len, clk, arst_n, out_valid && head_byte == HEAD_HALF, payload_bytes == BYTES_HALF && payload[63:16] == '0, "half form malformed")
	`SFE_ASSERT_NEXT(a_flow, clk, arst_n, ready && v_s2, out_valid, "stage 2 item lost")
endmodule
